/* rtl/core/rdeg_pkg.sv */
`default_nettype none
package rdeg_pkg;

	localparam int NODE_BITS = 16;
	localparam int ROW_BITS  = NODE_BITS + 1;
	localparam int COL_BITS  = 40;
	localparam int SAMPLE_BITS = 32;
	localparam int KEEP_BITS = 32;
	// log2 result: 6 bit exponent and 24 bit fraction
	localparam int LOG_FRAC  = 24;
	localparam int LOG_BITS  = 30;
	localparam int SKIP_BITS = 37;

	localparam logic [31:0] LN2_Q32 = 32'd2977044472;
	localparam logic [SKIP_BITS-1:0] SKIP_MAX = SKIP_BITS'(64'd1 << 36);
	localparam logic [LOG_BITS-1:0] LOG_ONE_32 = LOG_BITS'(32'd32 << LOG_FRAC);

	localparam logic [NODE_BITS-1:0] NODE_RESET = NODE_BITS'(16);
	localparam logic [KEEP_BITS-1:0] KEEP_RESET = 32'd11629080;

	localparam logic CMD_RESTART = 1'b0;
	localparam logic CMD_SAMPLE  = 1'b1;

	localparam logic CFG_NODE_COUNT = 1'b0;
	localparam logic CFG_NEG_LOG    = 1'b1;

	typedef enum logic [1:0] {
		ST_EDGE    = 2'd0,
		ST_DONE    = 2'd1,
		ST_INVALID = 2'd2
	} status_t;

endpackage
`default_nettype wire

/* rtl/core/rdeg_sample_if.sv */
`default_nettype none
interface rdeg_sample_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [31:0] uniform_sample;

	modport source (output valid, command, uniform_sample, input ready);
	modport sink   (input valid, command, uniform_sample, output ready);
endinterface
`default_nettype wire

/* rtl/core/rdeg_result_if.sv */
`default_nettype none
interface rdeg_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] from_node;
	logic [15:0] to_node;
	logic [1:0]  status;

	modport source (output valid, from_node, to_node, status, input ready);
	modport sink   (input valid, from_node, to_node, status, output ready);
endinterface
`default_nettype wire

/* rtl/core/rdeg_log2.sv */
`default_nettype none
// log2 of x in Q.24 by repeated squaring, one square per cycle
module rdeg_log2 (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [32:0] x,
	output logic             done,
	output logic [rdeg_pkg::LOG_BITS-1:0] res
);
	import rdeg_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [5:0]  exp_q;
	logic [31:0] mant_q;
	logic [LOG_FRAC-1:0] frac_q;

	logic [5:0]  lead;
	logic [31:0] norm;
	logic [63:0] sq;
	logic [32:0] sq_sh;

	always_comb begin
		lead = 6'd0;
		for (int i = 0; i < 33; i++) begin
			if (x[i]) lead = 6'(i);
		end
		if (lead == 6'd32) norm = x[32:1];
		else norm = 32'(x << (6'd31 - lead));
	end

	assign sq    = 64'(mant_q) * 64'(mant_q);
	assign sq_sh = sq[63:31];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(LOG_FRAC - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			exp_q  <= lead;
			mant_q <= norm;
			frac_q <= '0;
		end else if (busy_q) begin
			if (sq_sh[32]) mant_q <= sq_sh[32:1];
			else mant_q <= sq_sh[31:0];
			frac_q <= {frac_q[LOG_FRAC-2:0], sq_sh[32]};
		end
	end

	assign done = done_q;
	assign res  = {exp_q, frac_q};
endmodule
`default_nettype wire

/* rtl/core/rdeg_div.sv */
`default_nettype none
// restoring divider, one quotient bit per cycle
module rdeg_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [rdeg_pkg::LOG_BITS-1:0]  dividend,
	input  wire logic [rdeg_pkg::KEEP_BITS-1:0] divisor,
	output logic             done,
	output logic [rdeg_pkg::LOG_BITS-1:0] quotient
);
	import rdeg_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [LOG_BITS-1:0]  quo_q;
	logic [KEEP_BITS:0]   rem_q;
	logic [KEEP_BITS-1:0] dvs_q;

	logic [KEEP_BITS:0] trial;
	logic               fits;

	assign trial = {rem_q[KEEP_BITS-1:0], quo_q[LOG_BITS-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(LOG_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quo_q shifts dividend bits out at the top and quotient bits in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, dvs_q}) : trial;
			quo_q <= {quo_q[LOG_BITS-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

/* rtl/core/random_digraph_edge_generator.sv */
`default_nettype none
// channel   dir   payload
// sample    in    command, uniform_sample
// result    out   from_node, to_node, status
// cfg       in    cfg_we, cfg_index, cfg_data (plain write)
//
// a restart item is done when it is taken; a sample item in an invalid or
// finished state goes straight to the push state and the output register
// a sample item otherwise: squaring in the log unit, one multiply, the
// divider, then one row passed per cycle (about skip / node_count rows,
// never more than the rows left)
// reset puts row 0, column -1 and the register reset values in place
// one item at a time; a result waiting in the output register does not
// stop the next item, only the hand-over of its own result
module random_digraph_edge_generator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	rdeg_sample_if.sink      sample,
	rdeg_result_if.source    result,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data
);
	import rdeg_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOG  = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_ADD  = 3'd4;
	localparam logic [2:0] S_ADV  = 3'd5;
	localparam logic [2:0] S_PUSH = 3'd6;

	logic [2:0] state_q;

	// configuration registers
	logic [NODE_BITS-1:0] node_q;
	logic [KEEP_BITS-1:0] keep_q;

	// graph position
	logic [ROW_BITS-1:0]        row_q;
	logic signed [COL_BITS-1:0] col_q;

	// result waiting for the output register
	logic [15:0] pend_from_q;
	logic [15:0] pend_to_q;
	status_t     pend_stat_q;

	// output register
	logic        out_valid_q;
	logic [15:0] out_from_q;
	logic [15:0] out_to_q;
	status_t     out_stat_q;

	logic accept;
	logic log_start, log_done;
	logic div_start, div_done;
	logic [LOG_BITS-1:0] log_res, nl2, quo;
	logic [61:0] nln_full;
	logic [SKIP_BITS-1:0] skip;

	logic signed [COL_BITS-1:0] n_ext;
	logic signed [COL_BITS-1:0] row_ext;
	logic signed [COL_BITS-1:0] w_add;
	logic signed [COL_BITS-1:0] w_sub;
	logic [ROW_BITS-1:0]        row_inc;
	logic                       more_rows;
	logic                       slot_free;

	assign accept        = sample.valid && sample.ready;
	assign sample.ready  = (state_q == S_IDLE);
	assign slot_free     = !out_valid_q || result.ready;

	assign log_start = accept && (sample.command == CMD_SAMPLE) && (keep_q != '0)
		&& (row_q < {1'b0, node_q});

	rdeg_log2 u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (log_start),
		.x      (33'h1_0000_0000 - {1'b0, sample.uniform_sample}),
		.done   (log_done),
		.res    (log_res)
	);

	// -ln(1-u) = (32 - log2 x) * ln 2, Q.24; the divider captures it
	assign nl2       = LOG_ONE_32 - log_res;
	assign nln_full  = 62'(nl2) * 62'(LN2_Q32);
	assign div_start = (state_q == S_MUL);

	rdeg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (nln_full[61:32]),
		.divisor  (keep_q),
		.done     (div_done),
		.quotient (quo)
	);

	always_comb begin
		skip = SKIP_BITS'(quo);
		if (skip > SKIP_MAX) skip = SKIP_MAX;
	end

	assign n_ext   = COL_BITS'({1'b0, node_q});
	assign row_ext = COL_BITS'({1'b0, row_q});
	assign w_add   = col_q + COL_BITS'(1) + COL_BITS'(skip);
	assign w_sub   = col_q - n_ext;
	assign row_inc = row_q + ROW_BITS'(1);
	// another row to pass while the column lies at or beyond n
	assign more_rows = (col_q >= n_ext) && (row_q < {1'b0, node_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q <= NODE_RESET;
			keep_q <= KEEP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NODE_COUNT: node_q <= cfg_data[NODE_BITS-1:0];
				CFG_NEG_LOG:    keep_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_q       <= '0;
			col_q       <= '1;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (sample.command == CMD_RESTART) begin
							row_q <= '0;
							col_q <= '1;
						end else if (!log_start) begin
							state_q <= S_PUSH;
						end else begin
							state_q <= S_LOG;
						end
					end
				end
				S_LOG: if (log_done) state_q <= S_MUL;
				S_MUL: state_q <= S_DIV;
				S_DIV: if (div_done) state_q <= S_ADD;
				S_ADD: begin
					// first step past the diagonal
					col_q   <= (w_add == row_ext) ? w_add + COL_BITS'(1) : w_add;
					state_q <= S_ADV;
				end
				S_ADV: begin
					if (more_rows) begin
						row_q <= row_inc;
						col_q <= (w_sub == COL_BITS'({1'b0, row_inc})) ?
							w_sub + COL_BITS'(1) : w_sub;
					end else begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (slot_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output valid: set on hand-over, cleared once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_PUSH && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, filled as the item settles
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			pend_from_q <= '0;
			pend_to_q   <= '0;
			pend_stat_q <= (keep_q == '0) ? ST_INVALID : ST_DONE;
		end else if (state_q == S_ADV && !more_rows) begin
			if (row_q < {1'b0, node_q}) begin
				pend_from_q <= row_q[15:0];
				pend_to_q   <= col_q[15:0];
				pend_stat_q <= ST_EDGE;
			end else begin
				pend_from_q <= '0;
				pend_to_q   <= '0;
				pend_stat_q <= ST_DONE;
			end
		end
		if (state_q == S_PUSH && slot_free) begin
			out_from_q <= pend_from_q;
			out_to_q   <= pend_to_q;
			out_stat_q <= pend_stat_q;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.from_node = out_from_q;
	assign result.to_node   = out_to_q;
	assign result.status    = out_stat_q;

	// an edge never lands on the diagonal
	a_no_loop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stat_q == ST_EDGE) |-> (out_from_q != out_to_q))
		else $error("self loop emitted");

	// the row walk only runs on a row inside the graph
	a_walk_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADD) |-> (row_q < {1'b0, node_q}))
		else $error("row walk started past last row");

	// the divider is only started once the log unit has finished
	a_div_after_log: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> $past(state_q == S_LOG && log_done))
		else $error("divider started out of order");

	// a result is only handed over when the output register is free
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUSH && out_valid_q && !result.ready) |=> (state_q == S_PUSH))
		else $error("result overran output register");

endmodule
`default_nettype wire

/* tb/random_digraph_edge_generator_test.sv */
`default_nettype none
module random_digraph_edge_generator_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rdeg_pkg::*;

	localparam int  RANDOM_ITEMS = 1600;
	localparam int  CYCLE_LIMIT  = 60_000_000;
	// restarts end when taken, done/invalid items skip the log unit: covers any tail
	localparam int  SETTLE       = 40;

	typedef struct packed {
		logic [15:0] from_node;
		logic [15:0] to_node;
		status_t     status;
	} edge_t;

	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_ITEM
	} row_kind_t;

	// one line of the directed stimulus; expectation typed in where obvious
	typedef struct {
		row_kind_t   kind;
		logic        index;
		logic [31:0] data;
		logic        command;
		logic [31:0] sample;
		bit          typed;
		edge_t       want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;

	rdeg_sample_if sample ();
	rdeg_result_if result ();

	random_digraph_edge_generator u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample.sink),
		.result  (result.source),
		.cfg_we  (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// own copy of the generator state and registers
	logic [15:0]     nodes;
	logic [31:0]     keep_log;
	longint unsigned row_at;
	longint          col_at;

	edge_t pending_edges[$];
	int    errors = 0;
	int    cycles = 0;
	bit    calm = 1'b0;
	int    n_edges = 0, n_done = 0, n_invalid = 0, n_restart = 0, n_phases = 0;
	int    n_items = 0;

	// log2 of x in 1..2^32, Q.24, each square truncated
	function automatic longint unsigned log2_q24(longint unsigned x);
		int              e;
		longint unsigned m;
		longint unsigned r;
		e = 0;
		while (e < 32 && (x >> (e + 1)) != 0)
			e++;
		m = (e <= 31) ? (x << (31 - e)) : (x >> (e - 31));
		r = longint'(e) << LOG_FRAC;
		for (int i = LOG_FRAC - 1; i >= 0; i--) begin
			m = (m * m) >> 31;
			if (m >= 64'h1_0000_0000) begin
				m >>= 1;
				r |= 64'd1 << i;
			end
		end
		return r;
	endfunction

	// next edge of the graph for one sample; updates the state copy
	function automatic edge_t next_edge(logic [31:0] u);
		edge_t           e;
		longint unsigned n;
		longint unsigned skip;
		longint unsigned nl2;
		longint unsigned v;
		longint          w;
		e = '{from_node: '0, to_node: '0, status: ST_EDGE};
		n = longint'(nodes) & ((64'd1 << NODE_BITS) - 1);
		if (keep_log == 0) begin
			e.status = ST_INVALID;
			return e;
		end
		if (row_at >= n) begin
			e.status = ST_DONE;
			return e;
		end
		nl2  = (64'd32 << LOG_FRAC) - log2_q24(64'h1_0000_0000 - longint'(u));
		skip = ((nl2 * longint'(LN2_Q32)) >> 32) / longint'(keep_log);
		if (skip > longint'(SKIP_MAX))
			skip = longint'(SKIP_MAX);
		v = row_at;
		w = col_at + 1 + longint'(skip);
		if (longint'(v) == w)
			w++;
		// column reduced by n per row, diagonal stepped over
		while (w >= longint'(n) && v < n) begin
			w -= longint'(n);
			v++;
			if (longint'(v) == w)
				w++;
		end
		row_at = v;
		col_at = w;
		if (v < n) begin
			e.from_node = v[15:0];
			e.to_node   = w[15:0];
		end else begin
			e.status = ST_DONE;
		end
		return e;
	endfunction

	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, 12);
	endfunction

	// cycle count and timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("random_digraph_edge_generator regression: fail");
			$finish;
		end
	end

	// result side: random stall per item, then hold ready until taken
	initial begin
		int stall;
		result.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				result.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result.ready <= 1'b1;
			do @(posedge clk); while (!result.valid);
		end
	end

	// compare each taken result with the oldest expectation
	always @(posedge clk) begin
		edge_t got;
		edge_t want;
		if (arst_n && result.valid && result.ready) begin
			got = '{from_node: result.from_node, to_node: result.to_node,
				status: status_t'(result.status)};
			if (pending_edges.size() == 0) begin
				$error("result with nothing expected: status %0d", got.status);
				errors++;
			end else begin
				want = pending_edges.pop_front();
				if (got.from_node !== want.from_node) begin
					$error("from_node: expected %0d, got %0d", want.from_node, got.from_node);
					errors++;
				end
				if (got.to_node !== want.to_node) begin
					$error("to_node: expected %0d, got %0d", want.to_node, got.to_node);
					errors++;
				end
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					errors++;
				end
				case (want.status)
					ST_EDGE: n_edges++;
					ST_DONE: n_done++;
					default: n_invalid++;
				endcase
			end
		end
	end

	// drop valid and wait until every result is in, then let the block settle
	task automatic wait_idle();
		sample.valid <= 1'b0;
		while (pending_edges.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic index, logic [31:0] data);
		wait_idle();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		if (index == CFG_NODE_COUNT)
			nodes = data[15:0];
		else
			keep_log = data;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// hand one item over; returns at the edge that takes it, valid still high
	task automatic send_item(logic command, logic [31:0] u, bit typed, edge_t want);
		int    gap;
		edge_t e;
		gap = draw_gap();
		if (gap > 0) begin
			sample.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample.valid          <= 1'b1;
		sample.command        <= command;
		sample.uniform_sample <= u;
		do @(posedge clk); while (!sample.ready);
		n_items++;
		if (command == CMD_RESTART) begin
			row_at = 0;
			col_at = -1;
			n_restart++;
		end else begin
			e = next_edge(u);
			pending_edges.push_back(typed ? want : e);
		end
	endtask

	stim_row_t directed[$];

	function automatic stim_row_t cfg_row(logic index, logic [31:0] data);
		stim_row_t r;
		r = '{kind: ROW_CFG, index: index, data: data, command: CMD_SAMPLE,
			sample: '0, typed: 1'b0, want: '0};
		return r;
	endfunction

	function automatic stim_row_t item_row(logic command, logic [31:0] u);
		stim_row_t r;
		r = '{kind: ROW_ITEM, index: CFG_NODE_COUNT, data: '0, command: command,
			sample: u, typed: 1'b0, want: '0};
		return r;
	endfunction

	function automatic stim_row_t known_row(logic [31:0] u, int f, int t, status_t s);
		stim_row_t r;
		r = item_row(CMD_SAMPLE, u);
		r.typed = 1'b1;
		r.want  = '{from_node: 16'(f), to_node: 16'(t), status: s};
		return r;
	endfunction

	initial begin
		int          phase_len;
		int          pick;
		logic [31:0] u;
		logic [15:0] n_pick;
		logic [31:0] k_pick;

		sample.valid          <= 1'b0;
		sample.command        <= CMD_RESTART;
		sample.uniform_sample <= '0;
		nodes    = NODE_RESET;
		keep_log = KEEP_RESET;
		row_at   = 0;
		col_at   = -1;

		// after reset: n = 16, p = one half; zero sample means no skip
		directed.push_back(known_row(32'h0, 0, 1, ST_EDGE));
		directed.push_back(known_row(32'h0, 0, 2, ST_EDGE));
		directed.push_back(item_row(CMD_SAMPLE, 32'hFFFF_FFFF));
		directed.push_back(item_row(CMD_RESTART, 32'hFFFF_FFFF));
		directed.push_back(known_row(32'h0, 0, 1, ST_EDGE));
		// zero probability register: invalid, position kept
		directed.push_back(cfg_row(CFG_NEG_LOG, 32'h0));
		directed.push_back(known_row(32'hA5A5_A5A5, 0, 0, ST_INVALID));
		// single node: the only row has no edge but the diagonal
		directed.push_back(cfg_row(CFG_NEG_LOG, 32'hFFFF_FFFF));
		directed.push_back(cfg_row(CFG_NODE_COUNT, 32'd1));
		directed.push_back(known_row(32'h0, 0, 0, ST_DONE));
		directed.push_back(cfg_row(CFG_NODE_COUNT, 32'd0));
		directed.push_back(known_row(32'h1234_5678, 0, 0, ST_DONE));
		// widest graph with the smallest log: long row walks
		directed.push_back(cfg_row(CFG_NODE_COUNT, 32'hFFFF_FFFF));
		directed.push_back(cfg_row(CFG_NEG_LOG, 32'd1));
		directed.push_back(item_row(CMD_RESTART, 32'h0));
		directed.push_back(item_row(CMD_SAMPLE, 32'h8000_0000));
		directed.push_back(item_row(CMD_SAMPLE, 32'hFFFF_FFFF));
		directed.push_back(item_row(CMD_SAMPLE, 32'h0000_0001));
		// two nodes: edges step over the diagonal, then done
		directed.push_back(cfg_row(CFG_NODE_COUNT, 32'd2));
		directed.push_back(cfg_row(CFG_NEG_LOG, KEEP_RESET));
		directed.push_back(item_row(CMD_RESTART, 32'h0));
		directed.push_back(known_row(32'h0, 0, 1, ST_EDGE));
		directed.push_back(known_row(32'h0, 1, 0, ST_EDGE));
		directed.push_back(known_row(32'h0, 0, 0, ST_DONE));
		directed.push_back(known_row(32'hFFFF_FFFF, 0, 0, ST_DONE));
		// node count lowered so the current row lies outside the graph
		directed.push_back(cfg_row(CFG_NODE_COUNT, 32'd40));
		directed.push_back(item_row(CMD_RESTART, 32'h0));
		directed.push_back(item_row(CMD_SAMPLE, 32'hFFFF_FFFF));
		directed.push_back(item_row(CMD_SAMPLE, 32'hFFFF_0000));
		directed.push_back(cfg_row(CFG_NODE_COUNT, 32'd1));
		directed.push_back(item_row(CMD_SAMPLE, 32'h7FFF_FFFF));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_CFG)
				write_reg(directed[i].index, directed[i].data);
			else
				send_item(directed[i].command, directed[i].sample,
					directed[i].typed, directed[i].want);
		end

		// random phases: fresh registers, restart, then a run of samples with occasional restarts
		while (n_items < RANDOM_ITEMS + directed.size()) begin
			n_phases++;
			calm = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 70)
				n_pick = 16'($urandom_range(1, 24));
			else if (pick < 92)
				n_pick = 16'($urandom_range(25, 300));
			else if (pick < 95)
				n_pick = 16'hFFFF;
			else if (pick < 97)
				n_pick = 16'h0;
			else
				n_pick = 16'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 10)
				k_pick = 32'h0;
			else if (pick < 15)
				k_pick = 32'hFFFF_FFFF;
			else if (pick < 18)
				k_pick = 32'd1;
			else
				k_pick = $urandom_range(32'h0020_0000, 32'h0800_0000);
			if ($urandom_range(0, 1)) begin
				write_reg(CFG_NODE_COUNT, {16'($urandom), n_pick});
				write_reg(CFG_NEG_LOG, k_pick);
			end else begin
				write_reg(CFG_NEG_LOG, k_pick);
				write_reg(CFG_NODE_COUNT, {16'($urandom), n_pick});
			end
			send_item(CMD_RESTART, $urandom, 1'b0, '0);
			phase_len = $urandom_range(60, 140);
			repeat (phase_len) begin
				pick = $urandom_range(0, 99);
				if (pick < 8)
					u = 32'h0;
				else if (pick < 16)
					u = 32'hFFFF_FFFF;
				else
					u = $urandom;
				if ($urandom_range(0, 99) < 6)
					send_item(CMD_RESTART, u, 1'b0, '0);
				else
					send_item(CMD_SAMPLE, u, 1'b0, '0);
			end
		end

		wait_idle();
		repeat (100) @(posedge clk);
		$display("covered %0d items over %0d register settings, %0d restarts",
			n_items, n_phases, n_restart);
		$display("results: %0d edges, %0d finished, %0d invalid probability",
			n_edges, n_done, n_invalid);
		if (errors == 0)
			$display("random_digraph_edge_generator regression: pass");
		else
			$display("random_digraph_edge_generator regression: fail");
		$finish;
	end

endmodule
`default_nettype wire
